// ----- design/publish_ack_retry_tracker_macros.svh -----
// Assertion macros used by the tracker module.
`ifndef PUBLISH_ACK_RETRY_TRACKER_MACROS_SVH
`define PUBLISH_ACK_RETRY_TRACKER_MACROS_SVH
`ifndef SYNTH
`define PAT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tracker assertion failed");
`define PAT_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tracker reset assertion failed");
`else
`define PAT_ASSERT(lbl, prop)
`define PAT_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- design/pat_pkg.sv -----
`timescale 1ns / 1ps
package pat_pkg;

    localparam int REG_DEPTH_DEF = 16;
    localparam int EXP_DEPTH_DEF = 16;

    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int ID_W       = 16;
    localparam int NUM_W      = 32;
    localparam int CMD_W      = 3;
    localparam int TO_W       = 16;
    localparam int BUD_W      = 8;
    localparam int RES_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 152;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUBLISH    = 3'd0,
        CMD_ACK        = 3'd1,
        CMD_REGISTER   = 3'd2,
        CMD_UNREGISTER = 3'd3,
        CMD_TICK       = 3'd4,
        CMD_ADD        = 3'd5,
        CMD_REMOVE     = 3'd6,
        CMD_CHECK      = 3'd7
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_ENABLE  = 3'd0,
        CFG_BUDGET      = 3'd1,
        CFG_TIMEOUT     = 3'd2,
        CFG_OWN_IP      = 3'd3,
        CFG_OWN_PORT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SS_IDLE    = 2'd0,
        SS_SENDING = 2'd1,
        SS_ACKED   = 2'd2,
        SS_FAILED  = 2'd3
    } t_send_state;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_APPLY = 2'd3
    } t_fsm;

endpackage

// ----- design/pat_ram.sv -----
`timescale 1ns / 1ps
module pat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/publish_ack_retry_tracker.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake             | Payload
// s_ (cmd)  | in        | i_s_tvalid/o_s_tready | tdata: peers and ack, tuser: cmd
// m_ (res)  | out       | o_m_tvalid/i_m_tready | tdata: send result and flags
// cfg       | in        | i_cfg_valid/o_cfg_ready | index and data, always ready
// Every item passes through the accept step, a scan that makes one read of each key memory
// per entry up to max(REGISTERED_DEPTH, EXPECTED_DEPTH), a drain step for the last compare
// and an apply step that applies the update.
// Valid and acked marks live in flops, so reset clears the tables at once.
// A full result register holds the block in its apply step until the item is taken;
// a new item is accepted while the previous result still waits.
`include "publish_ack_retry_tracker_macros.svh"
module publish_ack_retry_tracker #(
    parameter int REGISTERED_DEPTH = pat_pkg::REG_DEPTH_DEF,
    parameter int EXPECTED_DEPTH   = pat_pkg::EXP_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [31:0] peer_ip, [47:32] peer_port, [63:48] peer_name_id,
    // [95:64] acked_origin_ip, [111:96] acked_origin_port,
    // [143:112] acked_pub_number, [144] check_all, rest zero
    input  logic [pat_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [2:0] cmd
    input  logic [pat_pkg::CMD_W-1:0]         i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] send_request, [32:1] pub_number, [34:33] send_state,
    // [35] check_ok, [36] ack_taken, [37] table_full, rest zero
    output logic [pat_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pat_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int RAW    = (REGISTERED_DEPTH > 1) ? $clog2(REGISTERED_DEPTH) : 1;
    localparam int EAW    = (EXPECTED_DEPTH > 1) ? $clog2(EXPECTED_DEPTH) : 1;
    localparam int SCAN_N = (REGISTERED_DEPTH > EXPECTED_DEPTH) ? REGISTERED_DEPTH
                                                                : EXPECTED_DEPTH;
    localparam int SW     = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int RKEY_W = pat_pkg::IP_W + pat_pkg::PORT_W;

    // Configuration.
    logic                      r_ack_enable;
    logic [pat_pkg::BUD_W-1:0] r_budget;
    logic [pat_pkg::TO_W-1:0]  r_ticks;
    logic [pat_pkg::IP_W-1:0]  r_own_ip;
    logic [pat_pkg::PORT_W-1:0] r_own_port;

    // Captured item.
    pat_pkg::t_cmd              r_cmd;
    logic [pat_pkg::IP_W-1:0]   r_peer_ip;
    logic [pat_pkg::PORT_W-1:0] r_peer_port;
    logic [pat_pkg::ID_W-1:0]   r_name_id;
    logic [pat_pkg::IP_W-1:0]   r_oip;
    logic [pat_pkg::PORT_W-1:0] r_oport;
    logic [pat_pkg::NUM_W-1:0]  r_anum;
    logic                       r_check_all;

    pat_pkg::t_fsm r_fsm, n_fsm;
    logic [SW-1:0] r_cnt;
    logic          r_cmp_vld;
    logic [SW-1:0] r_cmp_idx;

    logic [REGISTERED_DEPTH-1:0] r_reg_valid, n_reg_valid, r_reg_acked, n_reg_acked;
    logic [EXPECTED_DEPTH-1:0]   r_exp_valid, n_exp_valid, r_exp_acked, n_exp_acked;
    logic           r_reg_hit, r_reg_free, r_exp_hit, r_exp_free;
    logic [RAW-1:0] r_reg_hit_idx, r_reg_free_idx;
    logic [EAW-1:0] r_exp_hit_idx, r_exp_free_idx;

    logic [pat_pkg::NUM_W-1:0] r_next_num, n_next_num, r_last_num, n_last_num;
    logic                      r_sent_any, n_sent_any;
    logic [pat_pkg::RES_W-1:0] r_resends, n_resends;
    logic [pat_pkg::TO_W-1:0]  r_timeout, n_timeout;
    pat_pkg::t_send_state      r_send_state, n_send_state;

    logic                          r_out_valid;
    logic [pat_pkg::M_TDATA_W-1:0] r_out_data;

    logic s_accept, apply_go, scan_rd, scan_last;
    logic reg_we, exp_we;
    logic [RKEY_W-1:0]           reg_rdata;
    logic [pat_pkg::ID_W-1:0]    exp_rdata;
    logic in_reg, in_exp, reg_match, exp_match;
    logic [RAW-1:0] reg_cidx;
    logic [EAW-1:0] exp_cidx;
    logic send_req, check_ok, ack_taken, full;
    logic pend_reg, pend_exp;

    pat_ram #(.WIDTH(RKEY_W), .DEPTH(REGISTERED_DEPTH)) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (r_reg_free_idx),
        .i_wdata ({r_peer_ip, r_peer_port}),
        .i_raddr (r_cnt[RAW-1:0]),
        .o_rdata (reg_rdata)
    );

    pat_ram #(.WIDTH(pat_pkg::ID_W), .DEPTH(EXPECTED_DEPTH)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (exp_we),
        .i_waddr (r_exp_free_idx),
        .i_wdata (r_name_id),
        .i_raddr (r_cnt[EAW-1:0]),
        .o_rdata (exp_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign scan_last   = (r_cnt == SW'(SCAN_N - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_enable <= 1'b0;
            r_budget     <= '0;
            r_ticks      <= '0;
            r_own_ip     <= '0;
            r_own_port   <= '0;
        end else if (i_cfg_valid) begin
            unique case (pat_pkg::t_cfg_idx'(i_cfg_index))
                pat_pkg::CFG_ACK_ENABLE: r_ack_enable <= i_cfg_data[0];
                pat_pkg::CFG_BUDGET:     r_budget     <= i_cfg_data[pat_pkg::BUD_W-1:0];
                pat_pkg::CFG_TIMEOUT:    r_ticks      <= i_cfg_data[pat_pkg::TO_W-1:0];
                pat_pkg::CFG_OWN_IP:     r_own_ip     <= i_cfg_data[pat_pkg::IP_W-1:0];
                pat_pkg::CFG_OWN_PORT:   r_own_port   <= i_cfg_data[pat_pkg::PORT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd       <= pat_pkg::t_cmd'(i_s_tuser);
            r_peer_ip   <= i_s_tdata[31:0];
            r_peer_port <= i_s_tdata[47:32];
            r_name_id   <= i_s_tdata[63:48];
            r_oip       <= i_s_tdata[95:64];
            r_oport     <= i_s_tdata[111:96];
            r_anum      <= i_s_tdata[143:112];
            r_check_all <= i_s_tdata[144];
        end
    end

    // Sequencer: next state.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            pat_pkg::ST_IDLE:  if (i_s_tvalid) n_fsm = pat_pkg::ST_SCAN;
            pat_pkg::ST_SCAN:  if (scan_last) n_fsm = pat_pkg::ST_DRAIN;
            pat_pkg::ST_DRAIN: n_fsm = pat_pkg::ST_APPLY;
            pat_pkg::ST_APPLY: if (!r_out_valid || i_m_tready) n_fsm = pat_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        o_s_tready = 1'b0;
        scan_rd    = 1'b0;
        apply_go   = 1'b0;
        unique case (r_fsm)
            pat_pkg::ST_IDLE:  o_s_tready = 1'b1;
            pat_pkg::ST_SCAN:  scan_rd = 1'b1;
            pat_pkg::ST_DRAIN: ;
            pat_pkg::ST_APPLY: apply_go = !r_out_valid || i_m_tready;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= pat_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_fsm     <= n_fsm;
            r_cmp_vld <= scan_rd;
            if (s_accept) begin
                r_cnt <= '0;
            end else if (scan_rd && !scan_last) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt;
    end

    // Compare stage: the memory data of entry r_cmp_idx is valid now.
    assign reg_cidx  = r_cmp_idx[RAW-1:0];
    assign exp_cidx  = r_cmp_idx[EAW-1:0];
    assign in_reg    = r_cmp_vld && ({1'b0, r_cmp_idx} < (SW+1)'(REGISTERED_DEPTH));
    assign in_exp    = r_cmp_vld && ({1'b0, r_cmp_idx} < (SW+1)'(EXPECTED_DEPTH));
    assign reg_match = in_reg && r_reg_valid[reg_cidx]
                       && (reg_rdata == {r_peer_ip, r_peer_port});
    assign exp_match = in_exp && r_exp_valid[exp_cidx] && (exp_rdata == r_name_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || s_accept) begin
            r_reg_hit  <= 1'b0;
            r_reg_free <= 1'b0;
            r_exp_hit  <= 1'b0;
            r_exp_free <= 1'b0;
        end else begin
            if (reg_match && !r_reg_hit) begin
                r_reg_hit     <= 1'b1;
                r_reg_hit_idx <= reg_cidx;
            end
            if (in_reg && !r_reg_valid[reg_cidx] && !r_reg_free) begin
                r_reg_free     <= 1'b1;
                r_reg_free_idx <= reg_cidx;
            end
            if (exp_match && !r_exp_hit) begin
                r_exp_hit     <= 1'b1;
                r_exp_hit_idx <= exp_cidx;
            end
            if (in_exp && !r_exp_valid[exp_cidx] && !r_exp_free) begin
                r_exp_free     <= 1'b1;
                r_exp_free_idx <= exp_cidx;
            end
        end
    end

    assign pend_reg = |(r_reg_valid & ~r_reg_acked);
    assign pend_exp = |(r_exp_valid & ~r_exp_acked);

    // Apply step: read-modify-write of the marks and the sender state.
    always_comb begin
        logic                     resend;
        logic [pat_pkg::TO_W-1:0] tick_to;
        resend       = 1'b0;
        tick_to      = (r_timeout != '0) ? r_timeout - 1'b1 : '0;
        n_reg_valid  = r_reg_valid;
        n_reg_acked  = r_reg_acked;
        n_exp_valid  = r_exp_valid;
        n_exp_acked  = r_exp_acked;
        n_next_num   = r_next_num;
        n_last_num   = r_last_num;
        n_sent_any   = r_sent_any;
        n_resends    = r_resends;
        n_timeout    = r_timeout;
        n_send_state = r_send_state;
        reg_we       = 1'b0;
        exp_we       = 1'b0;
        send_req     = 1'b0;
        check_ok     = 1'b0;
        ack_taken    = 1'b0;
        full         = 1'b0;
        unique case (r_cmd)
            pat_pkg::CMD_PUBLISH: begin
                if (r_ack_enable) begin
                    n_reg_acked  = '0;
                    n_exp_acked  = '0;
                    n_send_state = pat_pkg::SS_SENDING;
                end else begin
                    n_send_state = pat_pkg::SS_ACKED;
                end
                n_last_num = r_next_num;
                n_sent_any = 1'b1;
                n_resends  = {1'b0, r_budget};
                n_next_num = r_next_num + 1'b1;
                send_req   = 1'b1;
                n_timeout  = r_ticks;
            end
            pat_pkg::CMD_ACK: begin
                if (r_ack_enable && r_oip == r_own_ip && r_oport == r_own_port
                    && r_sent_any && r_anum == r_last_num) begin
                    ack_taken = 1'b1;
                    if (r_reg_hit) begin
                        n_reg_acked[r_reg_hit_idx] = 1'b1;
                    end else if (r_reg_free) begin
                        reg_we                      = 1'b1;
                        n_reg_valid[r_reg_free_idx] = 1'b1;
                        n_reg_acked[r_reg_free_idx] = 1'b1;
                    end else begin
                        full = 1'b1;
                    end
                    if (r_exp_hit) begin
                        n_exp_acked[r_exp_hit_idx] = 1'b1;
                    end
                end
            end
            pat_pkg::CMD_REGISTER: begin
                if (r_ack_enable) begin
                    if (r_reg_hit) begin
                        resend = !r_reg_acked[r_reg_hit_idx];
                    end else if (r_reg_free) begin
                        reg_we                      = 1'b1;
                        n_reg_valid[r_reg_free_idx] = 1'b1;
                        n_reg_acked[r_reg_free_idx] = 1'b0;
                        resend                      = 1'b1;
                    end else begin
                        full   = 1'b1;
                        resend = 1'b1;
                    end
                end
            end
            pat_pkg::CMD_UNREGISTER: begin
                if (r_ack_enable && r_reg_hit) begin
                    n_reg_valid[r_reg_hit_idx] = 1'b0;
                    n_reg_acked[r_reg_hit_idx] = 1'b0;
                end
            end
            pat_pkg::CMD_TICK: begin
                if (r_ack_enable && !r_resends[pat_pkg::RES_W-1]) begin
                    n_timeout = tick_to;
                    if (tick_to == '0) begin
                        if (pend_reg || pend_exp) begin
                            if (r_resends == '0) begin
                                n_send_state = pat_pkg::SS_FAILED;
                            end else begin
                                resend = 1'b1;
                            end
                            n_resends = r_resends - 1'b1;
                        end else begin
                            n_send_state = pat_pkg::SS_ACKED;
                            n_resends    = '1;
                        end
                    end
                end
            end
            pat_pkg::CMD_ADD: begin
                if (r_ack_enable) begin
                    if (r_exp_hit) begin
                        n_exp_acked[r_exp_hit_idx] = 1'b0;
                    end else if (r_exp_free) begin
                        exp_we                      = 1'b1;
                        n_exp_valid[r_exp_free_idx] = 1'b1;
                        n_exp_acked[r_exp_free_idx] = 1'b0;
                    end else begin
                        full = 1'b1;
                    end
                end
            end
            pat_pkg::CMD_REMOVE: begin
                if (r_ack_enable && r_exp_hit) begin
                    n_exp_valid[r_exp_hit_idx] = 1'b0;
                    n_exp_acked[r_exp_hit_idx] = 1'b0;
                end
            end
            pat_pkg::CMD_CHECK: begin
                if (!r_ack_enable) begin
                    check_ok = 1'b1;
                end else if (r_check_all) begin
                    check_ok = !pend_exp;
                end else begin
                    check_ok = r_exp_hit && r_exp_acked[r_exp_hit_idx];
                end
            end
        endcase
        // A resend goes out only once something has been published.
        if (resend && r_sent_any) begin
            send_req  = 1'b1;
            n_timeout = r_ticks;
        end
        if (!apply_go) begin
            reg_we = 1'b0;
            exp_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_valid  <= '0;
            r_reg_acked  <= '0;
            r_exp_valid  <= '0;
            r_exp_acked  <= '0;
            r_next_num   <= '0;
            r_last_num   <= '0;
            r_sent_any   <= 1'b0;
            r_resends    <= '1;
            r_timeout    <= '0;
            r_send_state <= pat_pkg::SS_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            if (apply_go) begin
                r_reg_valid  <= n_reg_valid;
                r_reg_acked  <= n_reg_acked;
                r_exp_valid  <= n_exp_valid;
                r_exp_acked  <= n_exp_acked;
                r_next_num   <= n_next_num;
                r_last_num   <= n_last_num;
                r_sent_any   <= n_sent_any;
                r_resends    <= n_resends;
                r_timeout    <= n_timeout;
                r_send_state <= n_send_state;
                r_out_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_out_data <= {2'b00, full, ack_taken, check_ok, n_send_state,
                           n_last_num, send_req};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `PAT_ASSERT(a_accept_starts_scan, s_accept |=> (r_fsm == pat_pkg::ST_SCAN))
    `PAT_ASSERT(a_result_held, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
    `PAT_ASSERT(a_no_write_outside_apply, (reg_we || exp_we) |-> (r_fsm == pat_pkg::ST_APPLY))
    `PAT_ASSERT_RST(a_reset_clears, !i_rst_n |=> (r_fsm == pat_pkg::ST_IDLE && !o_m_tvalid))
endmodule
